// File: sv/pdup_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and control types of the pixel to DMX universe packer.
// Used by the controller, the datapath and the top level.
package pdup_pkg;

    localparam int SLOTS_DEFAULT = 512;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LAYOUT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_UNIV  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_SLOT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_RED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_GREEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_BLUE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_WHITE  = 3'd6;

    localparam logic [1:0] LAYOUT_MONO = 2'd0;
    localparam logic [1:0] LAYOUT_RGB  = 2'd1;
    localparam logic [1:0] LAYOUT_RGBW = 2'd2;
    localparam logic [1:0] LAYOUT_RGBX = 2'd3;

    localparam logic [15:0] GAIN_RESET = 16'd4096;

    localparam logic [15:0] LUMA_WR = 16'd13933;
    localparam logic [15:0] LUMA_WG = 16'd46871;
    localparam logic [15:0] LUMA_WB = 16'd4732;

    localparam logic [15:0] UNIV_LIMIT = 16'd32768;

    typedef struct packed {
        logic       load;
        logic       mix;
        logic       rnd;
        logic       wht;
        logic       emit;
        logic [1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic exhausted;
        logic out_free;
        logic emit_last;
    } t_status;

endpackage

// File: sv/pdup_pix_if.sv
`timescale 1ns / 1ps
// Input channel: one RGB pixel word with a frame-last flag.
// Stands alone; no package needed.
interface pdup_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_last;

    modport source (output valid, output red, output green, output blue,
                    output frame_last, input ready);
    modport sink (input valid, input red, input green, input blue,
                  input frame_last, output ready);
endinterface

// File: sv/pdup_dmx_if.sv
`timescale 1ns / 1ps
// Output channel: one DMX channel byte word with its universe and slot.
// Stands alone; no package needed.
interface pdup_dmx_if;
    logic        valid;
    logic        ready;
    logic [7:0]  level;
    logic [14:0] universe;
    logic [8:0]  slot;
    logic        packet_end;
    logic        pixel_done;

    modport source (output valid, output level, output universe, output slot,
                    output packet_end, output pixel_done, input ready);
    modport sink (input valid, input level, input universe, input slot,
                  input packet_end, input pixel_done, output ready);
endinterface

// File: sv/pdup_datapath.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, gain multipliers, luma and white arithmetic,
// universe and slot counters and the output word register. Uses pdup_pkg, pdup_dmx_if.
module pdup_datapath #(
    parameter int SLOTS_PER_UNIVERSE = pdup_pkg::SLOTS_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pdup_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pdup_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [7:0]                         i_red,
    input  logic [7:0]                         i_green,
    input  logic [7:0]                         i_blue,
    input  logic                               i_frame_last,
    input  pdup_pkg::t_cmd                     i_cmd,
    output pdup_pkg::t_status                  o_status,
    pdup_dmx_if.source                         o_dmx
);
    import pdup_pkg::*;

    localparam logic [8:0]  SLOT_LAST  = 9'(SLOTS_PER_UNIVERSE - 1);
    localparam logic [40:0] LUMA_HALF  = 41'(1) << 27;
    localparam logic [40:0] WHITE_HALF = 41'(1) << 23;

    function automatic logic [7:0] sat12(input logic [23:0] v);
        logic [24:0] s;
        s = {1'b0, v} + 25'h800;
        return (|s[24:20]) ? 8'hFF : s[19:12];
    endfunction

    logic [1:0]  r_layout;
    logic [14:0] r_start_univ;
    logic [8:0]  r_start_slot;
    logic [15:0] r_gain_r, r_gain_g, r_gain_b, r_gain_w;

    logic [15:0] r_ucnt;
    logic [8:0]  r_slot;
    logic        r_frame_start;
    logic        r_last;

    logic [23:0] r_cr, r_cg, r_cb, r_min;
    logic [39:0] r_pr, r_pg, r_pb, r_wprod;
    logic [7:0]  r_byte [4];

    logic        r_out_valid;
    logic [7:0]  r_o_level;
    logic [14:0] r_o_universe;
    logic [8:0]  r_o_slot;
    logic        r_o_packet_end;
    logic        r_o_pixel_done;

    logic [23:0] n_min;
    logic [40:0] w_luma_sum;
    logic [40:0] w_white_sum;
    logic        w_full;
    logic [1:0]  w_last_idx;
    logic        w_emit_last;
    logic [8:0]  w_start_slot;

    always_comb begin
        n_min = (r_cr < r_cg) ? r_cr : r_cg;
        n_min = (n_min < r_cb) ? n_min : r_cb;
    end

    assign w_luma_sum   = 41'(r_pr) + 41'(r_pg) + 41'(r_pb) + LUMA_HALF;
    assign w_white_sum  = 41'(r_wprod) + WHITE_HALF;
    assign w_full       = r_slot >= SLOT_LAST;
    assign w_start_slot = (r_start_slot > SLOT_LAST) ? SLOT_LAST : r_start_slot;

    always_comb begin
        case (r_layout)
            LAYOUT_MONO: w_last_idx = 2'd0;
            LAYOUT_RGB:  w_last_idx = 2'd2;
            default:     w_last_idx = 2'd3;
        endcase
    end

    assign w_emit_last = (i_cmd.idx == w_last_idx) ||
                         (w_full && (r_ucnt == UNIV_LIMIT - 16'd1));

    assign o_status.exhausted = r_ucnt >= UNIV_LIMIT;
    assign o_status.out_free  = !r_out_valid || o_dmx.ready;
    assign o_status.emit_last = w_emit_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout     <= LAYOUT_RGB;
            r_start_univ <= '0;
            r_start_slot <= '0;
            r_gain_r     <= GAIN_RESET;
            r_gain_g     <= GAIN_RESET;
            r_gain_b     <= GAIN_RESET;
            r_gain_w     <= GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LAYOUT:     r_layout     <= i_cfg_data[1:0];
                REG_START_UNIV: r_start_univ <= i_cfg_data[14:0];
                REG_START_SLOT: r_start_slot <= i_cfg_data[8:0];
                REG_GAIN_RED:   r_gain_r     <= i_cfg_data;
                REG_GAIN_GREEN: r_gain_g     <= i_cfg_data;
                REG_GAIN_BLUE:  r_gain_b     <= i_cfg_data;
                REG_GAIN_WHITE: r_gain_w     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ucnt        <= '0;
            r_slot        <= '0;
            r_frame_start <= 1'b1;
        end else if (i_cmd.load) begin
            r_frame_start <= i_frame_last;
            if (r_frame_start) begin
                r_ucnt <= {1'b0, r_start_univ};
                r_slot <= w_start_slot;
            end
        end else if (i_cmd.emit) begin
            if (w_full) begin
                r_slot <= '0;
                r_ucnt <= r_ucnt + 16'd1;
            end else begin
                r_slot <= r_slot + 9'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_last <= i_frame_last;
            r_cr   <= 24'(r_gain_r) * 24'(i_red);
            r_cg   <= 24'(r_gain_g) * 24'(i_green);
            r_cb   <= 24'(r_gain_b) * 24'(i_blue);
        end
        if (i_cmd.mix) begin
            r_min <= n_min;
            r_pr  <= 40'(LUMA_WR) * 40'(r_cr);
            r_pg  <= 40'(LUMA_WG) * 40'(r_cg);
            r_pb  <= 40'(LUMA_WB) * 40'(r_cb);
        end
        if (i_cmd.rnd) begin
            r_wprod <= 40'(r_gain_w) * 40'(r_min);
            case (r_layout)
                LAYOUT_MONO: begin
                    r_byte[0] <= (|w_luma_sum[40:36]) ? 8'hFF : w_luma_sum[35:28];
                    r_byte[1] <= '0;
                    r_byte[2] <= '0;
                end
                LAYOUT_RGBW: begin
                    r_byte[0] <= sat12(r_cr - r_min);
                    r_byte[1] <= sat12(r_cg - r_min);
                    r_byte[2] <= sat12(r_cb - r_min);
                end
                default: begin
                    r_byte[0] <= sat12(r_cr);
                    r_byte[1] <= sat12(r_cg);
                    r_byte[2] <= sat12(r_cb);
                end
            endcase
        end
        if (i_cmd.wht) begin
            if (r_layout == LAYOUT_RGBW) begin
                r_byte[3] <= (|w_white_sum[40:32]) ? 8'hFF : w_white_sum[31:24];
            end else begin
                r_byte[3] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_dmx.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_level      <= r_byte[i_cmd.idx];
            r_o_universe   <= r_ucnt[14:0];
            r_o_slot       <= r_slot;
            r_o_packet_end <= w_full || (w_emit_last && r_last);
            r_o_pixel_done <= w_emit_last;
        end
    end

    assign o_dmx.valid      = r_out_valid;
    assign o_dmx.level      = r_o_level;
    assign o_dmx.universe   = r_o_universe;
    assign o_dmx.slot       = r_o_slot;
    assign o_dmx.packet_end = r_o_packet_end;
    assign o_dmx.pixel_done = r_o_pixel_done;

endmodule

// File: sv/pdup_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences accept, three arithmetic steps and one byte emission per cycle
// while the output is free. Uses pdup_pkg for the command and status types.
module pdup_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pdup_pkg::t_status i_status,
    output pdup_pkg::t_cmd    o_cmd
);
    import pdup_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MIX  = 3'd1;
    localparam logic [2:0] S_RND  = 3'd2;
    localparam logic [2:0] S_WHT  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] r_state, n_state;
    logic [1:0] r_idx, n_idx;
    logic       w_emit;

    assign o_ready = r_state == S_IDLE;
    assign w_emit  = (r_state == S_EMIT) && !i_status.exhausted && i_status.out_free;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_valid) begin
                    n_state = S_MIX;
                end
            end
            S_MIX:  n_state = S_RND;
            S_RND:  n_state = S_WHT;
            S_WHT:  n_state = S_EMIT;
            S_EMIT: begin
                if (i_status.exhausted) begin
                    n_state = S_IDLE;
                end else if (w_emit) begin
                    if (i_status.emit_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_cmd.load = (r_state == S_IDLE) && i_valid;
    assign o_cmd.mix  = r_state == S_MIX;
    assign o_cmd.rnd  = r_state == S_RND;
    assign o_cmd.wht  = r_state == S_WHT;
    assign o_cmd.emit = w_emit;
    assign o_cmd.idx  = r_idx;

endmodule

// File: sv/pixel_to_dmx_universe_packer.sv
`timescale 1ns / 1ps
// Top level of the pixel to DMX universe packer: controller plus datapath.
// Uses pdup_pkg, pdup_pix_if, pdup_dmx_if, pdup_ctrl and pdup_datapath.
//
//   Channel   Direction  Word contents
//   i_pix     in         red, green, blue, frame_last
//   o_dmx     out        level, universe, slot, packet_end, pixel_done
//   i_cfg_*   in         write enable, register index, register data
//
// A pixel is accepted with its gain multiply, then takes three arithmetic steps
// (luma products, rounding and white product, white byte), then emits each channel byte.
// Reset is synchronous and restores the register defaults and arms a frame start.
// A stalled output holds the byte sequencer; the next pixel is taken as soon as
// the last byte sits in the output register, even if that word is not yet taken.
module pixel_to_dmx_universe_packer #(
    parameter int SLOTS_PER_UNIVERSE = pdup_pkg::SLOTS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pdup_pix_if.sink                        i_pix,
    pdup_dmx_if.source                      o_dmx,
    input  logic                            i_cfg_we,
    input  logic [pdup_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pdup_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pdup_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_ready;

    assign i_pix.ready = w_ready;

    pdup_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_pix.valid),
        .o_ready  (w_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    pdup_datapath #(
        .SLOTS_PER_UNIVERSE (SLOTS_PER_UNIVERSE)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_red        (i_pix.red),
        .i_green      (i_pix.green),
        .i_blue       (i_pix.blue),
        .i_frame_last (i_pix.frame_last),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_dmx        (o_dmx)
    );

endmodule

// File: verif/pdup_dmx_check_pkg.sv
`timescale 1ns / 1ps
// Word types and the DMX byte scoreboard for the pixel to DMX universe packer bench.
// Depends on pdup_pkg for register indexes, layout codes and the universe limit.
package pdup_dmx_check_pkg;
    import pdup_pkg::*;

    localparam longint unsigned WEIGHT_RED   = 13933;
    localparam longint unsigned WEIGHT_GREEN = 46871;
    localparam longint unsigned WEIGHT_BLUE  = 4732;
    localparam int MAX_REPORTS = 24;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_last;
    } pixel_word_t;

    typedef struct packed {
        logic [7:0]  level;
        logic [14:0] universe;
        logic [8:0]  slot;
        logic        packet_end;
        logic        pixel_done;
    } dmx_word_t;

    class dmx_byte_scoreboard;
        logic [1:0]  layout;
        logic [14:0] first_universe;
        logic [8:0]  first_slot;
        logic [15:0] gain_r;
        logic [15:0] gain_g;
        logic [15:0] gain_b;
        logic [15:0] gain_w;
        int unsigned universe_now;
        int unsigned slot_now;
        bit          frame_armed;
        dmx_word_t   expected_bytes[$];
        int          errors;
        int          pixels;
        int          bytes_checked;
        int          frames;
        int          packets;
        int          dropped;

        function new();
            layout = LAYOUT_RGB;
            first_universe = '0;
            first_slot = '0;
            gain_r = GAIN_RESET;
            gain_g = GAIN_RESET;
            gain_b = GAIN_RESET;
            gain_w = GAIN_RESET;
            universe_now = 0;
            slot_now = 0;
            frame_armed = 1'b1;
            errors = 0;
            pixels = 0;
            bytes_checked = 0;
            frames = 0;
            packets = 0;
            dropped = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_LAYOUT:     layout = data[1:0];
                REG_START_UNIV: first_universe = data[14:0];
                REG_START_SLOT: first_slot = data[8:0];
                REG_GAIN_RED:   gain_r = data;
                REG_GAIN_GREEN: gain_g = data;
                REG_GAIN_BLUE:  gain_b = data;
                REG_GAIN_WHITE: gain_w = data;
                default: ;
            endcase
        endfunction

        function logic [7:0] round_sat(longint unsigned v, int unsigned frac);
            longint unsigned r;
            r = (v + (64'd1 << (frac - 1))) >> frac;
            return (r > 255) ? 8'd255 : r[7:0];
        endfunction

        function void note_pixel(pixel_word_t p);
            longint unsigned cr, cg, cb, m;
            logic [7:0]      lv[4];
            dmx_word_t       words[4];
            int              nb;
            int              n;
            bit              full;
            cr = 64'(gain_r) * 64'(p.red);
            cg = 64'(gain_g) * 64'(p.green);
            cb = 64'(gain_b) * 64'(p.blue);
            pixels++;
            if (frame_armed) begin
                universe_now = first_universe;
                slot_now = (first_slot < SLOTS_DEFAULT) ? first_slot : SLOTS_DEFAULT - 1;
                frame_armed = 1'b0;
            end
            lv[3] = 8'd0;
            case (layout)
                LAYOUT_MONO: begin
                    lv[0] = round_sat(WEIGHT_RED * cr + WEIGHT_GREEN * cg + WEIGHT_BLUE * cb, 28);
                    nb = 1;
                end
                LAYOUT_RGBW: begin
                    m = (cr < cg) ? cr : cg;
                    m = (m < cb) ? m : cb;
                    lv[0] = round_sat(cr - m, 12);
                    lv[1] = round_sat(cg - m, 12);
                    lv[2] = round_sat(cb - m, 12);
                    lv[3] = round_sat(64'(gain_w) * m, 24);
                    nb = 4;
                end
                default: begin
                    lv[0] = round_sat(cr, 12);
                    lv[1] = round_sat(cg, 12);
                    lv[2] = round_sat(cb, 12);
                    nb = (layout == LAYOUT_RGBX) ? 4 : 3;
                end
            endcase
            n = 0;
            for (int i = 0; i < nb; i++) begin
                if (universe_now >= UNIV_LIMIT) begin
                    break;
                end
                full = (slot_now + 1 >= SLOTS_DEFAULT);
                words[n] = {lv[i], universe_now[14:0], slot_now[8:0], full, 1'b0};
                if (full) begin
                    slot_now = 0;
                    universe_now++;
                end else begin
                    slot_now++;
                end
                n++;
            end
            dropped += nb - n;
            if (n > 0) begin
                words[n-1].pixel_done = 1'b1;
                if (p.frame_last) begin
                    words[n-1].packet_end = 1'b1;
                end
            end
            for (int i = 0; i < n; i++) begin
                if (words[i].packet_end) begin
                    packets++;
                end
                expected_bytes = {expected_bytes, words[i]};
            end
            if (p.frame_last) begin
                frame_armed = 1'b1;
                frames++;
            end
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%0t ns: byte %0d %s mismatch, expected %0d, actual %0d",
                         $time, bytes_checked, field, want, got);
            end
        endfunction

        function void check_byte(dmx_word_t got);
            dmx_word_t want;
            if (expected_bytes.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t ns: unexpected byte, expected none, actual %h", $time, got);
                end
                return;
            end
            want = expected_bytes.pop_front();
            if (got.level !== want.level) report("level", want.level, got.level);
            if (got.universe !== want.universe) report("universe", want.universe, got.universe);
            if (got.slot !== want.slot) report("slot", want.slot, got.slot);
            if (got.packet_end !== want.packet_end) begin
                report("packet_end", want.packet_end, got.packet_end);
            end
            if (got.pixel_done !== want.pixel_done) begin
                report("pixel_done", want.pixel_done, got.pixel_done);
            end
            bytes_checked++;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

endpackage

// File: verif/tb_pixel_to_dmx_universe_packer.sv
`timescale 1ns / 1ps
// Top-level bench for the pixel to DMX universe packer: drives pixel words and register
// writes, checks every DMX byte word. Depends on pdup_pkg, pdup_dmx_check_pkg and the RTL.
module tb_pixel_to_dmx_universe_packer;
    import pdup_pkg::*;
    import pdup_dmx_check_pkg::*;

    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 24;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pdup_pix_if pix ();
    pdup_dmx_if dmx ();

    pixel_to_dmx_universe_packer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix),
        .o_dmx      (dmx),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    dmx_byte_scoreboard sb;
    int                 rx_mode;
    logic [7:0]         rx_pattern;
    logic [2:0]         rx_step;
    int                 hold_left;
    int                 idle_cycles;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        pix.valid = 1'b0;
        pix.red = '0;
        pix.green = '0;
        pix.blue = '0;
        pix.frame_last = 1'b0;
        dmx.ready = 1'b0;
        rx_mode = RX_ALWAYS;
        rx_pattern = 8'hFF;
        rx_step = '0;
        hold_left = 0;
        idle_cycles = 0;
        sb = new();
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (dmx.valid && dmx.ready) begin
            sb.check_byte({dmx.level, dmx.universe, dmx.slot, dmx.packet_end, dmx.pixel_done});
        end
        rx_step <= rx_step + 3'd1;
        if (hold_left > 0) begin
            dmx.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            case (rx_mode)
                RX_RANDOM:  dmx.ready <= ($urandom_range(0, 9) < 7);
                RX_PATTERN: dmx.ready <= rx_pattern[rx_step];
                default:    dmx.ready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((pix.valid && pix.ready) || (dmx.valid && dmx.ready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("pixel_to_dmx_universe_packer verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
    endtask

    task automatic offer(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                         input logic last);
        pixel_word_t p;
        p = {r, g, b, last};
        pix.valid <= 1'b1;
        pix.red <= r;
        pix.green <= g;
        pix.blue <= b;
        pix.frame_last <= last;
        do @(posedge i_clk); while (pix.ready !== 1'b1);
        sb.note_pixel(p);
    endtask

    task automatic stop_offer();
        pix.valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return GAIN_RESET;
            3: return 16'($urandom_range(2048, 8192));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_pixels(input int count, input int max_burst, input int max_gap,
                              input int last_odds);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, max_burst);
            for (int k = 0; k < burst && left > 0; k++) begin
                offer(pick_level(), pick_level(), pick_level(),
                      $urandom_range(0, last_odds) == 0);
                left--;
            end
            gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
            if (left > 0 && gap > 0) begin
                stop_offer();
                repeat (gap) @(posedge i_clk);
            end
        end
        stop_offer();
    endtask

    initial begin
        logic [15:0] univ_pick;
        logic [15:0] slot_pick;
        int          odds;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        rx_mode = RX_ALWAYS;
        offer(8'd0, 8'd0, 8'd0, 1'b0);
        offer(8'd255, 8'd255, 8'd255, 1'b0);
        offer(8'd1, 8'd128, 8'd254, 1'b1);
        stop_offer();
        drain();

        write_reg(REG_LAYOUT, 16'(LAYOUT_MONO));
        write_reg(REG_GAIN_RED, 16'hFFFF);
        write_reg(REG_GAIN_GREEN, 16'd0);
        write_reg(REG_GAIN_BLUE, 16'd2048);
        end_writes();
        offer(8'd255, 8'd255, 8'd255, 1'b0);
        offer(8'd1, 8'd1, 8'd1, 1'b0);
        offer(8'd0, 8'd0, 8'd1, 1'b1);
        stop_offer();
        drain();

        write_reg(REG_LAYOUT, 16'(LAYOUT_RGBW));
        write_reg(REG_GAIN_RED, GAIN_RESET);
        write_reg(REG_GAIN_GREEN, 16'd8192);
        write_reg(REG_GAIN_BLUE, GAIN_RESET);
        write_reg(REG_GAIN_WHITE, 16'hFFFF);
        end_writes();
        offer(8'd200, 8'd100, 8'd50, 1'b0);
        offer(8'd10, 8'd10, 8'd10, 1'b0);
        offer(8'd255, 8'd0, 8'd255, 1'b1);
        stop_offer();
        drain();

        // The frame-last byte lands on the final slot of the universe.
        write_reg(REG_LAYOUT, 16'(LAYOUT_RGB));
        write_reg(REG_START_UNIV, 16'd100);
        write_reg(REG_START_SLOT, 16'd509);
        end_writes();
        offer(8'd7, 8'd8, 8'd9, 1'b1);
        stop_offer();
        drain();

        write_reg(REG_LAYOUT, 16'(LAYOUT_RGBX));
        write_reg(REG_START_SLOT, 16'd510);
        end_writes();
        offer(8'd1, 8'd2, 8'd3, 1'b0);
        offer(8'd4, 8'd5, 8'd6, 1'b1);
        stop_offer();
        drain();

        // The last universe fills up and later bytes are dropped.
        write_reg(REG_LAYOUT, 16'(LAYOUT_RGBW));
        write_reg(REG_START_UNIV, 16'd32767);
        write_reg(REG_START_SLOT, 16'd511);
        write_reg(REG_GAIN_WHITE, GAIN_RESET);
        end_writes();
        offer(8'd90, 8'd40, 8'd200, 1'b0);
        offer(8'd1, 8'd2, 8'd3, 1'b0);
        offer(8'd4, 8'd5, 8'd6, 1'b1);
        offer(8'd70, 8'd80, 8'd90, 1'b1);
        stop_offer();
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 7))
                0: univ_pick = 16'd32767;
                1: univ_pick = 16'd32766;
                2: univ_pick = 16'd0;
                default: univ_pick = 16'($urandom_range(0, 32767));
            endcase
            case ($urandom_range(0, 3))
                0: slot_pick = 16'd0;
                1: slot_pick = 16'd511;
                default: slot_pick = 16'($urandom_range(0, 511));
            endcase
            write_reg(REG_LAYOUT, 16'(ph % 4));
            write_reg(REG_START_UNIV, univ_pick);
            write_reg(REG_START_SLOT, slot_pick);
            write_reg(REG_GAIN_RED, pick_gain());
            write_reg(REG_GAIN_GREEN, pick_gain());
            write_reg(REG_GAIN_BLUE, pick_gain());
            write_reg(REG_GAIN_WHITE, pick_gain());
            end_writes();
            rx_mode = $urandom_range(RX_ALWAYS, RX_PATTERN);
            rx_pattern = 8'($urandom_range(1, 255));
            if (ph == 2 || ph == 6) begin
                hold_left = 80;
            end
            case (ph % 3)
                0: odds = 2;
                1: odds = 10;
                default: odds = 60;
            endcase
            run_pixels(36, 12, (ph % 3 == 0) ? 0 : 6, odds);
            drain();
        end

        $display("Run covered %0d pixels in %0d frames over all four layouts, %0d DMX bytes",
                 sb.pixels, sb.frames, sb.bytes_checked);
        $display("checked, %0d packets closed and %0d bytes dropped past the last universe.",
                 sb.packets, sb.dropped);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("pixel_to_dmx_universe_packer verification clean");
        end else begin
            $display("pixel_to_dmx_universe_packer verification failed");
        end
        $finish;
    end

endmodule
